[rtl/core/crcfrc_pkg.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrc_pkg - shared types and constants for the CRC-16 frame checker
// Byte classes passed from the front to the back, verdict codes, the
// result layout and the reflected CRC-16 byte update.
// ---------------------------------------------------------------------------
package crcfrc_pkg;

    // Fixed frame layout
    localparam logic [7:0]  FRAME_OVERHEAD  = 8'd6;
    localparam logic [7:0]  CRC_HI_OFFSET   = 8'd3;
    localparam logic [7:0]  CRC_LO_OFFSET   = 8'd2;
    localparam logic [7:0]  TERMINATOR_BYTE = 8'hFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;

    // Configuration register indexes
    localparam int unsigned CFG_INDEX_W          = 1;
    localparam logic [CFG_INDEX_W-1:0] REG_OWN_ADDRESS      = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BROADCAST_ACTION = 1'd1;

    // Class of a received byte, settled by the front
    typedef enum logic [2:0] {
        KIND_SHORT_LEN,
        KIND_LENGTH,
        KIND_ADDR,
        KIND_ACTION,
        KIND_BODY,
        KIND_CRC_HI,
        KIND_CRC_LO,
        KIND_TERM
    } byte_kind_t;

    typedef enum logic [2:0] {
        VERDICT_OK             = 3'd0,
        VERDICT_BAD_LENGTH     = 3'd1,
        VERDICT_BAD_TERMINATOR = 3'd2,
        VERDICT_NOT_ADDRESSED  = 3'd3,
        VERDICT_BAD_CRC        = 3'd4
    } verdict_t;

    // Item held in the queue between front and back
    typedef struct packed {
        byte_kind_t  kind;
        logic [7:0]  data;
    } mid_item_t;

    // Result item
    typedef struct packed {
        verdict_t    verdict;
        logic [7:0]  action;
        logic [7:0]  payload;
    } result_t;

    // One byte of CRC-16, reflected polynomial, LSB first
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage
`default_nettype wire

[rtl/core/crcfrc_fifo.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrc_fifo - small register queue
// Flop storage, first-word fall-through read, full and empty flags.
// ---------------------------------------------------------------------------
module crcfrc_fifo #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 2
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic [WIDTH-1:0]      pop_data,
    output logic                  empty
);
    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == FULL_CNT);
    assign empty    = (count_reg == '0);
    assign pop_data = store_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

[rtl/core/crcfrc_front.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrc_front - byte classifier
// Tracks the position within the frame and tags each byte with its role.
// ---------------------------------------------------------------------------
module crcfrc_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [7:0]            data_byte,
    output logic                       mid_push,
    output crcfrc_pkg::mid_item_t      mid_item
);
    import crcfrc_pkg::*;

    logic [7:0] pos_reg, pos_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] crc_hi_pos, crc_lo_pos;
    byte_kind_t kind;

    assign crc_hi_pos = len_reg - CRC_HI_OFFSET;
    assign crc_lo_pos = len_reg - CRC_LO_OFFSET;

    // classify the byte and advance the position
    always_comb
    begin
        pos_next = pos_reg;
        len_next = len_reg;
        kind     = KIND_BODY;
        if (pos_reg == '0)
        begin
            len_next = data_byte;
            if (data_byte < FRAME_OVERHEAD)
            begin
                kind = KIND_SHORT_LEN;
            end
            else
            begin
                kind     = KIND_LENGTH;
                pos_next = 8'd1;
            end
        end
        else
        begin
            pos_next = pos_reg + 8'd1;
            if (pos_reg < crc_hi_pos)
            begin
                if (pos_reg == 8'd1)
                    kind = KIND_ADDR;
                else if (pos_reg == 8'd2)
                    kind = KIND_ACTION;
                else
                    kind = KIND_BODY;
            end
            else if (pos_reg == crc_hi_pos)
            begin
                kind = KIND_CRC_HI;
            end
            else if (pos_reg == crc_lo_pos)
            begin
                kind = KIND_CRC_LO;
            end
            else
            begin
                kind     = KIND_TERM;
                pos_next = '0;
            end
        end
    end

    assign mid_push      = in_valid;
    assign mid_item.kind = kind;
    assign mid_item.data = data_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            len_reg <= '0;
        end
        else if (in_valid)
        begin
            pos_reg <= pos_next;
            len_reg <= len_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/crcfrc_back.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// crcfrc_back - CRC and verdict unit
// Runs the CRC over classified bytes, captures the header and the
// received CRC, and forms one result at each frame end.
// ---------------------------------------------------------------------------
module crcfrc_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  mid_empty,
    input  wire crcfrc_pkg::mid_item_t mid_item,
    output logic                       mid_pop,
    input  wire logic                  out_full,
    output logic                       out_push,
    output crcfrc_pkg::result_t        out_item,
    input  wire logic [7:0]            own_address,
    input  wire logic [7:0]            broadcast_action
);
    import crcfrc_pkg::*;

    logic [15:0] crc_reg, crc_next;
    logic [15:0] rx_crc_reg, rx_crc_next;
    logic [7:0]  addr_reg, addr_next;
    logic [7:0]  action_reg, action_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc_step;
    verdict_t    term_verdict;

    // take an item whenever a result slot is free
    assign mid_pop  = !mid_empty && !out_full;
    assign crc_step = crc16_byte(crc_reg, mid_item.data);

    // frame-end checks in priority order
    always_comb
    begin
        if (mid_item.data != TERMINATOR_BYTE)
            term_verdict = VERDICT_BAD_TERMINATOR;
        else if (addr_reg != own_address && action_reg != broadcast_action)
            term_verdict = VERDICT_NOT_ADDRESSED;
        else if (rx_crc_reg != crc_reg)
            term_verdict = VERDICT_BAD_CRC;
        else
            term_verdict = VERDICT_OK;
    end

    // state update and result forming
    always_comb
    begin
        crc_next    = crc_reg;
        rx_crc_next = rx_crc_reg;
        addr_next   = addr_reg;
        action_next = action_reg;
        len_next    = len_reg;
        out_push    = 1'b0;
        out_item    = '{verdict: VERDICT_OK, action: action_reg,
                        payload: len_reg - FRAME_OVERHEAD};
        case (mid_item.kind)
            KIND_SHORT_LEN:
            begin
                len_next = mid_item.data;
                crc_next = CRC_INIT;
                out_push = mid_pop;
                out_item = '{verdict: VERDICT_BAD_LENGTH, action: 8'h00,
                            payload: 8'h00};
            end
            KIND_LENGTH:
            begin
                len_next = mid_item.data;
                crc_next = crc16_byte(CRC_INIT, mid_item.data);
            end
            KIND_ADDR:
            begin
                addr_next = mid_item.data;
                crc_next  = crc_step;
            end
            KIND_ACTION:
            begin
                action_next = mid_item.data;
                crc_next    = crc_step;
            end
            KIND_BODY:
            begin
                crc_next = crc_step;
            end
            KIND_CRC_HI:
            begin
                rx_crc_next = {mid_item.data, 8'h00};
            end
            KIND_CRC_LO:
            begin
                rx_crc_next = {rx_crc_reg[15:8], mid_item.data};
            end
            KIND_TERM:
            begin
                crc_next         = CRC_INIT;
                out_push         = mid_pop;
                out_item.verdict = term_verdict;
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg    <= CRC_INIT;
            rx_crc_reg <= '0;
            addr_reg   <= '0;
            action_reg <= '0;
            len_reg    <= '0;
        end
        else if (mid_pop)
        begin
            crc_reg    <= crc_next;
            rx_crc_reg <= rx_crc_next;
            addr_reg   <= addr_next;
            action_reg <= action_next;
            len_reg    <= len_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/crc16_frame_receive_check.sv]
`default_nettype none
// ---------------------------------------------------------------------------
// crc16_frame_receive_check - receive-side frame checker with CRC-16
// Checks length-prefixed frames (length, address, action, payload, CRC
// high, CRC low, 0xFF) and reports one verdict item per frame.
// ---------------------------------------------------------------------------
// The block takes one byte per clock cycle while full is low. A front stage
// classifies each byte by its place in the frame and writes it into a short
// queue; a back stage pops one byte a cycle while the result queue has room,
// runs a one-byte CRC-16 update (reflected 0xA001, init 0xFFFF) and at the
// frame end writes a verdict into the result queue, whose head drives the
// result ports. Sustained rate is one byte per cycle while results are popped,
// set by the combinational CRC byte update. full rises only when results are
// not popped and both queues fill up. Configuration writes take effect at
// once and are meant to be made while no frame is in flight.
// ---------------------------------------------------------------------------
module crc16_frame_receive_check #(
    parameter int unsigned MID_DEPTH = 2,
    parameter int unsigned OUT_DEPTH = 2
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    // byte input
    input  wire logic                                push,
    output logic                                     full,
    input  wire logic [7:0]                          data_byte,
    // result output
    output logic                                     empty,
    input  wire logic                                pop,
    output logic [2:0]                               verdict,
    output logic [7:0]                               action_code,
    output logic [7:0]                               payload_count,
    // configuration
    input  wire logic                                cfg_write,
    input  wire logic [crcfrc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [7:0]                          cfg_data
);
    import crcfrc_pkg::*;

    logic        mid_push, mid_full, mid_pop, mid_empty;
    mid_item_t   mid_in, mid_out;
    logic        out_push, out_full;
    result_t     out_in, out_head;
    logic        in_valid;
    logic [7:0]  own_address_reg;
    logic [7:0]  broadcast_action_reg;

    assign in_valid = push && !full;
    assign full     = mid_full;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            own_address_reg      <= '0;
            broadcast_action_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_OWN_ADDRESS:      own_address_reg      <= cfg_data;
                REG_BROADCAST_ACTION: broadcast_action_reg <= cfg_data;
                default:              own_address_reg      <= own_address_reg;
            endcase
        end
    end

    // byte classifier
    crcfrc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .data_byte (data_byte),
        .mid_push  (mid_push),
        .mid_item  (mid_in)
    );

    // queue between classifier and checker
    crcfrc_fifo #(
        .WIDTH ($bits(mid_item_t)),
        .DEPTH (MID_DEPTH)
    ) u_mid_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (mid_push),
        .push_data (mid_in),
        .full      (mid_full),
        .pop       (mid_pop),
        .pop_data  (mid_out),
        .empty     (mid_empty)
    );

    // CRC and verdict
    crcfrc_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .mid_empty        (mid_empty),
        .mid_item         (mid_out),
        .mid_pop          (mid_pop),
        .out_full         (out_full),
        .out_push         (out_push),
        .out_item         (out_in),
        .own_address      (own_address_reg),
        .broadcast_action (broadcast_action_reg)
    );

    // result queue
    crcfrc_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (out_push),
        .push_data (out_in),
        .full      (out_full),
        .pop       (pop),
        .pop_data  (out_head),
        .empty     (empty)
    );

    assign verdict       = out_head.verdict;
    assign action_code   = out_head.action;
    assign payload_count = out_head.payload;

    // checks
    a_out_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> !out_full)
        else $error("result written into a full result queue");

    a_mid_pop_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        mid_pop |-> !mid_empty && !out_full)
        else $error("checker took a byte without room for its result");

    a_short_len_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && verdict == VERDICT_BAD_LENGTH) |->
            (payload_count == 8'h00 && action_code == 8'h00))
        else $error("bad length result carries non-zero fields");

endmodule
`default_nettype wire

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top - testbench for the CRC-16 frame receive checker
// Drives byte streams made of well-formed frames, corrupted frames, short
// length bytes and stray bytes. A frame tracker in the bench predicts each
// verdict item, and every popped result is compared with the oldest one.
// Both handshakes idle at random, and the result side is stalled once for
// long enough to fill the block.
// ---------------------------------------------------------------------------
module tb_top;
    import crcfrc_pkg::*;

    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned STALL_CYCLES  = 400;
    localparam int unsigned TIMEOUT_NS    = 3000000;

    typedef struct {
        verdict_t   verdict;
        logic [7:0] action;
        logic [7:0] payload;
    } verdict_item_t;

    logic                   clk;
    logic                   rst_n;
    logic                   push;
    logic                   full;
    logic [7:0]             data_byte;
    logic                   empty;
    logic                   pop;
    logic [2:0]             verdict;
    logic [7:0]             action_code;
    logic [7:0]             payload_count;
    logic                   cfg_write;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [7:0]             cfg_data;

    // Frame tracker state and register copies
    logic [7:0]  trk_pos;
    logic [7:0]  trk_len;
    logic [7:0]  trk_addr;
    logic [7:0]  trk_action;
    logic [15:0] trk_crc;
    logic [15:0] trk_crc_rx;
    logic [7:0]  cur_own_address;
    logic [7:0]  cur_broadcast_action;

    verdict_item_t pending_verdicts[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned stall_left;
    int unsigned bytes_sent;
    int unsigned errors;

    crc16_frame_receive_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .data_byte     (data_byte),
        .empty         (empty),
        .pop           (pop),
        .verdict       (verdict),
        .action_code   (action_code),
        .payload_count (payload_count),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(TIMEOUT_NS);
        $display("crc16_frame_receive_check verification failed");
        $finish;
    end

    // Reflected CRC-16, one byte, LSB first
    function automatic logic [15:0] crc16_next(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {8'h00, b};
        repeat (8)
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        return r;
    endfunction

    // Track one accepted byte; queue a verdict when a frame ends
    function automatic void track_byte(input logic [7:0] b);
        verdict_item_t v;
        if (trk_pos == 8'd0)
        begin
            trk_len = b;
            if (b < FRAME_OVERHEAD)
            begin
                // short length: frame ends on this byte
                v.verdict = VERDICT_BAD_LENGTH;
                v.action  = 8'd0;
                v.payload = 8'd0;
                pending_verdicts.push_back(v);
                trk_crc = CRC_INIT;
            end
            else
            begin
                trk_crc = crc16_next(CRC_INIT, b);
                trk_pos = 8'd1;
            end
        end
        else if (trk_pos < trk_len - 8'd3)
        begin
            trk_crc = crc16_next(trk_crc, b);
            if (trk_pos == 8'd1)
                trk_addr = b;
            else if (trk_pos == 8'd2)
                trk_action = b;
            trk_pos = trk_pos + 8'd1;
        end
        else if (trk_pos == trk_len - 8'd3)
        begin
            trk_crc_rx = {b, 8'h00};
            trk_pos    = trk_pos + 8'd1;
        end
        else if (trk_pos == trk_len - 8'd2)
        begin
            trk_crc_rx[7:0] = b;
            trk_pos         = trk_pos + 8'd1;
        end
        else
        begin
            // terminator slot: first failing check wins
            if (b != TERMINATOR_BYTE)
                v.verdict = VERDICT_BAD_TERMINATOR;
            else if (trk_addr != cur_own_address && trk_action != cur_broadcast_action)
                v.verdict = VERDICT_NOT_ADDRESSED;
            else if (trk_crc_rx != trk_crc)
                v.verdict = VERDICT_BAD_CRC;
            else
                v.verdict = VERDICT_OK;
            v.action  = trk_action;
            v.payload = trk_len - FRAME_OVERHEAD;
            pending_verdicts.push_back(v);
            trk_pos = 8'd0;
            trk_crc = CRC_INIT;
        end
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_val,
                                        input logic [7:0] act_val);
        if (exp_val !== act_val)
        begin
            errors++;
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_val, act_val);
        end
    endfunction

    // Result check: each popped item against the oldest pending verdict
    always @(posedge clk)
    begin
        verdict_item_t v;
        if (rst_n && pop && !empty)
        begin
            if (pending_verdicts.size() == 0)
            begin
                errors++;
                $display("%0t: result with no frame pending: expected none, actual %0d/%0d/%0d",
                         $time, verdict, action_code, payload_count);
            end
            else
            begin
                v = pending_verdicts.pop_front();
                check_field("verdict", 8'(v.verdict), 8'(verdict));
                check_field("action_code", v.action, action_code);
                check_field("payload_count", v.payload, payload_count);
            end
        end
    end

    // Result side: random pops, or a counted hold-off when requested
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            pop <= 1'b0;
            stall_left = stall_left - 1;
        end
        else
            pop <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Offer one byte, with random idle cycles first; returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(negedge clk);
        end
        push      <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (full);
        track_byte(b);
        bytes_sent++;
        @(negedge clk);
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] addr,
                              input logic [7:0] act, input bit bad_crc,
                              input logic [7:0] term);
        logic [15:0] c;
        logic [7:0]  b;
        c = crc16_next(CRC_INIT, len);
        send_byte(len);
        c = crc16_next(c, addr);
        send_byte(addr);
        c = crc16_next(c, act);
        send_byte(act);
        repeat (len - FRAME_OVERHEAD)
        begin
            b = 8'($urandom_range(255));
            c = crc16_next(c, b);
            send_byte(b);
        end
        if (bad_crc)
            c = c ^ (16'h0001 << $urandom_range(15));
        send_byte(c[15:8]);
        send_byte(c[7:0]);
        send_byte(term);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] val);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_write <= 1'b0;
        if (idx == REG_OWN_ADDRESS)
            cur_own_address = val;
        else
            cur_broadcast_action = val;
        @(negedge clk);
    endtask

    // Close any open frame, then wait for every verdict and let the block settle
    task automatic settle_block();
        while (trk_pos != 8'd0)
            send_byte(8'h00);
        push <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Every verdict at reset register values, smallest lengths
    task automatic test_directed_frames();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        send_byte(8'd0);
        send_byte(FRAME_OVERHEAD - 8'd1);
        send_frame(FRAME_OVERHEAD, 8'h00, 8'h5A, 1'b0, TERMINATOR_BYTE);
        send_frame(FRAME_OVERHEAD, 8'h00, 8'h5A, 1'b0, 8'h00);
        send_frame(FRAME_OVERHEAD, 8'h33, 8'h5A, 1'b0, TERMINATOR_BYTE);
        // broadcast action from a foreign address
        send_frame(FRAME_OVERHEAD, 8'h33, 8'h00, 1'b0, TERMINATOR_BYTE);
        send_frame(FRAME_OVERHEAD, 8'h00, 8'h5A, 1'b1, TERMINATOR_BYTE);
        settle_block();
    endtask

    // Mostly well-formed frames with random content, some broken ones
    task automatic run_random_phase(input int unsigned n, input int unsigned s_idle,
                                    input int unsigned r_idle);
        int unsigned target;
        int unsigned pick;
        logic [7:0]  len;
        logic [7:0]  addr;
        logic [7:0]  act;
        logic [7:0]  term;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        target = bytes_sent + n;
        while (bytes_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                send_byte(8'($urandom_range(255)));
            else if (pick < 10)
                send_byte(8'($urandom_range(FRAME_OVERHEAD - 1)));
            else
            begin
                // realign after stray bytes with random filler
                while (trk_pos != 8'd0)
                    send_byte(8'($urandom_range(255)));
                len  = ($urandom_range(119) == 0) ? 8'd255 : 8'($urandom_range(14, FRAME_OVERHEAD));
                addr = ($urandom_range(1) == 1) ? cur_own_address : 8'($urandom_range(255));
                act  = ($urandom_range(3) == 0) ? cur_broadcast_action : 8'($urandom_range(255));
                term = ($urandom_range(11) == 0) ? 8'($urandom_range(254)) : TERMINATOR_BYTE;
                send_frame(len, addr, act, $urandom_range(9) == 0, term);
            end
        end
        settle_block();
    endtask

    task automatic test_random_traffic();
        write_reg(REG_OWN_ADDRESS, 8'h00);
        write_reg(REG_BROADCAST_ACTION, 8'hFF);
        run_random_phase(600, 21, 86);
        write_reg(REG_OWN_ADDRESS, 8'hFF);
        write_reg(REG_BROADCAST_ACTION, 8'h00);
        run_random_phase(600, 86, 21);
        write_reg(REG_OWN_ADDRESS, 8'($urandom_range(255)));
        write_reg(REG_BROADCAST_ACTION, 8'($urandom_range(255)));
        run_random_phase(600, 0, 0);
    endtask

    // Hold results back so both queues fill and full rises
    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        stall_left    = STALL_CYCLES;
        repeat (40)
            send_byte(8'($urandom_range(FRAME_OVERHEAD - 1)));
        send_frame(FRAME_OVERHEAD, cur_own_address, 8'h3C, 1'b0, TERMINATOR_BYTE);
        settle_block();
    endtask

    // Sequence
    initial
    begin
        rst_n                = 1'b0;
        push                 = 1'b0;
        pop                  = 1'b0;
        data_byte            = 8'h00;
        cfg_write            = 1'b0;
        cfg_index            = REG_OWN_ADDRESS;
        cfg_data             = 8'h00;
        send_idle_pct        = 0;
        recv_idle_pct        = 0;
        stall_left           = 0;
        bytes_sent           = 0;
        errors               = 0;
        trk_pos              = 8'd0;
        trk_len              = 8'd0;
        trk_addr             = 8'd0;
        trk_action           = 8'd0;
        trk_crc              = CRC_INIT;
        trk_crc_rx           = 16'h0000;
        cur_own_address      = 8'h00;
        cur_broadcast_action = 8'h00;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_frames();
        test_random_traffic();
        test_output_backpressure();
        settle_block();

        if (errors == 0)
            $display("crc16_frame_receive_check verification clean");
        else
            $display("crc16_frame_receive_check verification failed");
        $finish;
    end

endmodule
